>>> sv/rtpst_pkg.sv
// Shared types and constants of the RTP sequence tracker.
package rtpst_pkg;

  localparam int SEQ_BITS   = 16;
  localparam int CNT_W      = 32;
  localparam int FRAC_W     = 8;
  localparam int PROB_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Sequence space and the "bad sequence" code that matches no real sequence.
  localparam logic [SEQ_BITS:0] SEQ_SPACE = 17'd65536;
  localparam logic [SEQ_BITS:0] NO_MATCH  = SEQ_SPACE + 17'd1;
  localparam logic [FRAC_W-1:0] FRAC_SAT  = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DROP_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REORDER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH    = 2'd2;

  // Configuration reset values.
  localparam logic [SEQ_BITS-1:0] DROP_LIMIT_RST    = 16'd3000;
  localparam logic [SEQ_BITS-1:0] REORDER_LIMIT_RST = 16'd100;
  localparam logic [PROB_W-1:0]   RUN_LENGTH_RST    = 4'd2;

  // Input item kinds.
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [SEQ_BITS-1:0] seq_number;
  } in_data_t;

  typedef struct packed {
    logic              accepted;
    logic [FRAC_W-1:0] fraction_lost;
    logic [CNT_W-1:0]  extended_max_seq;
    logic [CNT_W-1:0]  received_count;
    logic [CNT_W-1:0]  expected_count;
  } out_data_t;

  // State update requested by the packet decision logic.
  typedef struct packed {
    logic                accepted;
    logic                resync;
    logic                rcv_inc;
    logic                hs_we;
    logic [SEQ_BITS-1:0] hs_new;
    logic                wrap_inc;
    logic                bad_we;
    logic [SEQ_BITS:0]   bad_new;
    logic                prob_we;
    logic [PROB_W-1:0]   prob_new;
  } pkt_upd_t;

endpackage

>>> sv/rtp_sequence_tracker_unit.sv
// Top level of the RTP sequence tracker: sequencer, state registers and shared subtractor.
//
// This unit tracks the sequence numbers of one RTP source and keeps the loss
// accounting used in receiver reports. Each input transaction is either a
// packet arrival, which runs probation, in-order, jump and resync handling and
// reports whether the packet counted as received, or a report request, which
// returns the fraction lost since the previous report in 1/256 units
// (saturating at 255). Every transaction yields exactly one result
// transaction carrying the extended highest sequence, the received count and
// the expected count after the update. The unit works on one transaction at a
// time and holds in_stall high until its result has moved into the output
// register. A packet passes through the packet update step and the output
// step. A report first takes the expected count; the first report after
// synchronization then only takes the snapshots, and later ones go on
// through the interval and lost steps, a compare step unless the fraction is
// zero, and the division unless the fraction saturates. One 33-bit subtractor
// is shared by every report step and produces one quotient bit per cycle of
// the 8-bit restoring division. Configuration writes are always ready and
// should be issued only while the unit is idle.
module rtp_sequence_tracker_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rtpst_pkg::in_data_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rtpst_pkg::out_data_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rtpst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtpst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rtpst_pkg::*;

  // Sequencer codes.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PKT    = 4'd1;
  localparam logic [3:0] ST_R_EXP  = 4'd2;
  localparam logic [3:0] ST_R_EINT = 4'd3;
  localparam logic [3:0] ST_R_RINT = 4'd4;
  localparam logic [3:0] ST_R_LOST = 4'd5;
  localparam logic [3:0] ST_R_CMP  = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  localparam logic [2:0] DIV_LAST = 3'(FRAC_W - 1);

  // Sequencer and output register.
  logic [3:0]  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_data_t   out_data_r, out_data_nxt;

  // Configuration registers.
  logic [SEQ_BITS-1:0] drop_lim_r, drop_lim_nxt;
  logic [SEQ_BITS-1:0] reorder_lim_r, reorder_lim_nxt;
  logic [PROB_W-1:0]   min_seq_r, min_seq_nxt;

  // Source state.
  logic [SEQ_BITS-1:0] base_r, base_nxt;
  logic [SEQ_BITS-1:0] hs_r, hs_nxt;
  logic [SEQ_BITS:0]   bad_r, bad_nxt;
  logic [SEQ_BITS-1:0] wrap_r, wrap_nxt;
  logic [CNT_W-1:0]    rcv_r, rcv_nxt;
  logic [CNT_W-1:0]    rar_r, rar_nxt;
  logic [CNT_W-1:0]    ear_r, ear_nxt;
  logic [PROB_W-1:0]   prob_r, prob_nxt;

  // Working registers of the current transaction.
  logic [SEQ_BITS-1:0] seq_r, seq_nxt;
  logic                kind_r, kind_nxt;
  logic [CNT_W-1:0]    exp_r, exp_nxt;
  logic [CNT_W-1:0]    eint_r, eint_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [FRAC_W-1:0]   quo_r, quo_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic                acc_r, acc_nxt;

  // Shared subtractor: res = a - b + one, with the borrow in the top bit.
  logic [CNT_W:0]   alu_a, alu_b;
  logic             alu_one;
  logic [CNT_W+1:0] alu_res;
  logic             alu_borrow;

  logic             in_fire, out_load;
  logic [CNT_W-1:0] ext_max;
  pkt_upd_t         upd;

  rtpst_pkt_logic u_pkt (
    .seq           (seq_r),
    .highest_seq   (hs_r),
    .bad_seq       (bad_r),
    .probation     (prob_r),
    .drop_limit    (drop_lim_r),
    .reorder_limit (reorder_lim_r),
    .run_length    (min_seq_r),
    .upd           (upd)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ext_max   = {wrap_r, hs_r};
  // In the output step the result register takes a new value when it is empty or being drained.
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // Operand selection for the shared subtractor. Idle, the packet step, the
  // expected-count step and the output step all compute ext_max - base + 1.
  always_comb begin
    alu_a   = {1'b0, ext_max};
    alu_b   = {17'd0, base_r};
    alu_one = 1'b1;
    case (state_r)
      ST_R_EINT: begin
        alu_a   = {1'b0, exp_r};
        alu_b   = {1'b0, ear_r};
        alu_one = 1'b0;
      end
      ST_R_RINT: begin
        alu_a   = {1'b0, rcv_r};
        alu_b   = {1'b0, rar_r};
        alu_one = 1'b0;
      end
      ST_R_LOST: begin
        alu_a   = {1'b0, eint_r};
        alu_b   = {1'b0, rem_r};
        alu_one = 1'b0;
      end
      ST_R_CMP: begin
        alu_a   = {1'b0, rem_r};
        alu_b   = {1'b0, eint_r};
        alu_one = 1'b0;
      end
      ST_DIV: begin
        alu_a   = {rem_r, 1'b0};
        alu_b   = {1'b0, eint_r};
        alu_one = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign alu_res    = {1'b0, alu_a} - {1'b0, alu_b} + {{(CNT_W+1){1'b0}}, alu_one};
  assign alu_borrow = alu_res[CNT_W+1];

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    drop_lim_nxt    = drop_lim_r;
    reorder_lim_nxt = reorder_lim_r;
    min_seq_nxt     = min_seq_r;
    base_nxt        = base_r;
    hs_nxt          = hs_r;
    bad_nxt         = bad_r;
    wrap_nxt        = wrap_r;
    rcv_nxt         = rcv_r;
    rar_nxt         = rar_r;
    ear_nxt         = ear_r;
    prob_nxt        = prob_r;
    seq_nxt         = seq_r;
    kind_nxt        = kind_r;
    exp_nxt         = exp_r;
    eint_nxt        = eint_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    frac_nxt        = frac_r;
    acc_nxt         = acc_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DROP_LIMIT:    drop_lim_nxt    = cfg_data;
        REG_REORDER_LIMIT: reorder_lim_nxt = cfg_data;
        REG_RUN_LENGTH:    min_seq_nxt     = cfg_data[PROB_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          seq_nxt   = in_data.seq_number;
          kind_nxt  = in_data.kind;
          acc_nxt   = 1'b0;
          frac_nxt  = '0;
          state_nxt = (in_data.kind == KIND_REPORT) ? ST_R_EXP : ST_PKT;
        end
      end
      ST_PKT: begin
        acc_nxt = upd.accepted;
        if (upd.prob_we) begin
          prob_nxt = upd.prob_new;
        end
        if (upd.resync) begin
          base_nxt = seq_r;
          hs_nxt   = seq_r;
          bad_nxt  = NO_MATCH;
          wrap_nxt = '0;
          rcv_nxt  = {{(CNT_W-1){1'b0}}, upd.rcv_inc};
          rar_nxt  = '0;
          ear_nxt  = '0;
        end else begin
          if (upd.hs_we) begin
            hs_nxt = upd.hs_new;
          end
          if (upd.wrap_inc) begin
            wrap_nxt = wrap_r + 16'd1;
          end
          if (upd.bad_we) begin
            bad_nxt = upd.bad_new;
          end
          if (upd.rcv_inc) begin
            rcv_nxt = rcv_r + 32'd1;
          end
        end
        state_nxt = ST_OUT;
      end
      ST_R_EXP: begin
        exp_nxt = alu_res[CNT_W-1:0];
        if (ear_r == '0) begin
          // First report after synchronization only takes the snapshots.
          ear_nxt   = alu_res[CNT_W-1:0];
          rar_nxt   = rcv_r;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_R_EINT;
        end
      end
      ST_R_EINT: begin
        eint_nxt  = alu_res[CNT_W-1:0];
        ear_nxt   = exp_r;
        state_nxt = ST_R_RINT;
      end
      ST_R_RINT: begin
        rem_nxt   = alu_res[CNT_W-1:0];
        rar_nxt   = rcv_r;
        state_nxt = ST_R_LOST;
      end
      ST_R_LOST: begin
        rem_nxt = alu_res[CNT_W-1:0];
        if (eint_r == '0 || alu_res[CNT_W-1:0] == '0 || alu_res[CNT_W-1]) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_R_CMP;
        end
      end
      ST_R_CMP: begin
        // Lost at least the expected interval means the fraction saturates.
        if (!alu_borrow) begin
          frac_nxt  = FRAC_SAT;
          state_nxt = ST_OUT;
        end else begin
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!alu_borrow) begin
          rem_nxt = alu_res[CNT_W-1:0];
        end else begin
          rem_nxt = {rem_r[CNT_W-2:0], 1'b0};
        end
        quo_nxt = {quo_r[FRAC_W-2:0], !alu_borrow};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == DIV_LAST) begin
          frac_nxt  = {quo_r[FRAC_W-2:0], !alu_borrow};
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.accepted         = acc_r;
          out_data_nxt.fraction_lost    = frac_r;
          out_data_nxt.extended_max_seq = ext_max;
          out_data_nxt.received_count   = rcv_r;
          out_data_nxt.expected_count   = alu_res[CNT_W-1:0];
          state_nxt                     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      drop_lim_r    <= DROP_LIMIT_RST;
      reorder_lim_r <= REORDER_LIMIT_RST;
      min_seq_r     <= RUN_LENGTH_RST;
      base_r        <= '0;
      hs_r          <= '0;
      bad_r         <= NO_MATCH;
      wrap_r        <= '0;
      rcv_r         <= '0;
      rar_r         <= '0;
      ear_r         <= '0;
      prob_r        <= 4'd1;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      drop_lim_r    <= drop_lim_nxt;
      reorder_lim_r <= reorder_lim_nxt;
      min_seq_r     <= min_seq_nxt;
      base_r        <= base_nxt;
      hs_r          <= hs_nxt;
      bad_r         <= bad_nxt;
      wrap_r        <= wrap_nxt;
      rcv_r         <= rcv_nxt;
      rar_r         <= rar_nxt;
      ear_r         <= ear_nxt;
      prob_r        <= prob_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    seq_r      <= seq_nxt;
    kind_r     <= kind_nxt;
    exp_r      <= exp_nxt;
    eint_r     <= eint_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    frac_r     <= frac_nxt;
    acc_r      <= acc_nxt;
  end

  // A report must never reach the packet update step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PKT) |-> (kind_r == KIND_PACKET))
    else $error("report transaction entered the packet update step");

  // The division remainder always stays below the expected interval.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < eint_r))
    else $error("division remainder not below the divisor");

  // While the source is on probation nothing has been counted as received.
  assert property (@(posedge clk) disable iff (!rst_n)
    (prob_r != '0) |-> (rcv_r == '0))
    else $error("packets counted during probation");

  // A result never carries both an accepted packet and a loss fraction.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.fraction_lost != '0) |-> !out_data_r.accepted)
    else $error("result marks a packet accepted with a loss fraction");

  // An accepted transaction always starts the sequencer.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted transaction did not start the sequencer");

endmodule

>>> sv/rtpst_pkt_logic.sv
// Packet decision logic: probation, in-order, jump and misorder classification.
module rtpst_pkt_logic (
  input  logic [rtpst_pkg::SEQ_BITS-1:0] seq,
  input  logic [rtpst_pkg::SEQ_BITS-1:0] highest_seq,
  input  logic [rtpst_pkg::SEQ_BITS:0]   bad_seq,
  input  logic [rtpst_pkg::PROB_W-1:0]   probation,
  input  logic [rtpst_pkg::SEQ_BITS-1:0] drop_limit,
  input  logic [rtpst_pkg::SEQ_BITS-1:0] reorder_limit,
  input  logic [rtpst_pkg::PROB_W-1:0]   run_length,
  output rtpst_pkg::pkt_upd_t            upd
);
  import rtpst_pkg::*;

  logic [SEQ_BITS-1:0] gap;
  logic [SEQ_BITS:0]   misorder_lim;
  logic                in_sequence;

  assign gap          = seq - highest_seq;
  assign misorder_lim = SEQ_SPACE - {1'b0, reorder_limit};
  // No wrap here: after 65535 the probation sequence restarts.
  assign in_sequence  = ({1'b0, seq} == ({1'b0, highest_seq} + 17'd1));

  always_comb begin
    upd = '0;
    upd.hs_new  = seq;
    upd.bad_new = {1'b0, seq + 16'd1};
    if (probation != '0) begin
      upd.hs_we   = 1'b1;
      upd.prob_we = 1'b1;
      if (in_sequence) begin
        upd.prob_new = probation - 4'd1;
        if (probation == 4'd1) begin
          upd.resync   = 1'b1;
          upd.rcv_inc  = 1'b1;
          upd.accepted = 1'b1;
        end
      end else begin
        upd.prob_new = run_length - 4'd1;
      end
    end else if (gap < drop_limit) begin
      upd.wrap_inc = (seq < highest_seq);
      upd.hs_we    = 1'b1;
      upd.rcv_inc  = 1'b1;
      upd.accepted = 1'b1;
    end else if ({1'b0, gap} <= misorder_lim) begin
      if ({1'b0, seq} == bad_seq) begin
        upd.resync   = 1'b1;
        upd.rcv_inc  = 1'b1;
        upd.accepted = 1'b1;
      end else begin
        upd.bad_we = 1'b1;
      end
    end else begin
      // Duplicate or reordered packet: counted, state unchanged.
      upd.rcv_inc  = 1'b1;
      upd.accepted = 1'b1;
    end
  end

endmodule

>>> tb/sv/rtp_sequence_tracker_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the RTP sequence tracker unit.
module rtp_sequence_tracker_unit_tb;
  import rtpst_pkg::*;

  // A stretch this long without any accepted transaction on any channel means
  // the unit has hung. The slowest correct transaction is a report with a
  // divide behind a heavy receiver stall run, far below this.
  localparam int QUIET_LIMIT = 4000;
  // Items of each randomized phase, eight phases in all.
  localparam int PHASE_ITEMS = 155;
  // Mismatch lines printed before the log goes quiet.
  localparam int PRINT_LIMIT = 40;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_data_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_data_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DROP_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  rtp_sequence_tracker_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be sent, tracker results still to come, and the number of
  // items queued whose result has not arrived yet (zero means the unit is idle).
  in_data_t  pending_items[$];
  out_data_t expected_results[$];
  int        results_owed = 0;
  int        mismatches   = 0;
  int        quiet_cycles = 0;

  // Shadow copy of the tracker state and its three limits.
  logic [15:0] lim_dropout  = DROP_LIMIT_RST;
  logic [15:0] lim_misorder = REORDER_LIMIT_RST;
  logic [3:0]  lim_min_seq  = RUN_LENGTH_RST;

  logic [15:0] trk_base      = '0;
  logic [15:0] trk_highest   = '0;
  logic [16:0] trk_bad       = NO_MATCH;
  logic [15:0] trk_wraps     = '0;
  logic [31:0] trk_rcv       = '0;
  logic [31:0] trk_rcv_snap  = '0;
  logic [31:0] trk_exp_snap  = '0;
  logic [3:0]  trk_probation = 4'd1;

  // Rough copy of the sequence logic used only to shape the stimulus, so that
  // most random packets land in order relative to what the unit has seen.
  logic [15:0] gen_cursor = '0;
  logic [16:0] gen_bad    = NO_MATCH;

  // Sender burst and gap counters, receiver stall pattern.
  int          burst_left     = 1;
  int          gap_left       = 0;
  stall_mode_t stall_mode     = STALL_NONE;
  int          stall_run_left = 0;

  // ---------------------------------------------------------------------------
  // Tracker prediction.
  // ---------------------------------------------------------------------------

  // Synchronization: the packet becomes the new base and every count and
  // report snapshot starts over.
  function automatic void restart_tracking(input logic [15:0] s);
    trk_base     = s;
    trk_highest  = s;
    trk_bad      = NO_MATCH;
    trk_wraps    = '0;
    trk_rcv      = '0;
    trk_rcv_snap = '0;
    trk_exp_snap = '0;
  endfunction

  function automatic logic [31:0] ext_highest();
    return {trk_wraps, trk_highest};
  endfunction

  function automatic logic [31:0] expected_total();
    return ext_highest() - {16'd0, trk_base} + 32'd1;
  endfunction

  function automatic out_data_t predict_transaction(input in_data_t item);
    out_data_t   res;
    logic [15:0] s;
    logic [15:0] gap;
    logic [15:0] nxt;
    logic [16:0] jump_lim;
    logic [31:0] exp_now;
    logic [31:0] exp_int;
    logic [31:0] rcv_int;
    logic [31:0] lost;
    logic [39:0] quot;
    res      = '0;
    s        = item.seq_number;
    gap      = s - trk_highest;
    nxt      = s + 16'd1;
    jump_lim = SEQ_SPACE - {1'b0, lim_misorder};
    if (item.kind == KIND_PACKET) begin
      if (trk_probation != 4'd0) begin
        // Probation: consecutive means highest + 1 without a 16-bit wrap.
        if ({1'b0, s} == {1'b0, trk_highest} + 17'd1) begin
          trk_probation = trk_probation - 4'd1;
          trk_highest   = s;
          if (trk_probation == 4'd0) begin
            restart_tracking(s);
            trk_rcv      = trk_rcv + 32'd1;
            res.accepted = 1'b1;
          end
        end else begin
          trk_probation = lim_min_seq - 4'd1;
          trk_highest   = s;
        end
      end else if (gap < lim_dropout) begin
        if (s < trk_highest) begin
          trk_wraps = trk_wraps + 16'd1;
        end
        trk_highest  = s;
        trk_rcv      = trk_rcv + 32'd1;
        res.accepted = 1'b1;
      end else if ({1'b0, gap} <= jump_lim) begin
        // A large jump is only believed when the very next packet follows it.
        if ({1'b0, s} == trk_bad) begin
          restart_tracking(s);
          trk_rcv      = trk_rcv + 32'd1;
          res.accepted = 1'b1;
        end else begin
          trk_bad = {1'b0, nxt};
        end
      end else begin
        // Duplicate or reordered packet: counted, highest left alone.
        trk_rcv      = trk_rcv + 32'd1;
        res.accepted = 1'b1;
      end
    end else begin
      exp_now = expected_total();
      if (trk_exp_snap == 32'd0) begin
        // First report after synchronization only takes the snapshots.
        trk_exp_snap = exp_now;
        trk_rcv_snap = trk_rcv;
      end else begin
        exp_int      = exp_now - trk_exp_snap;
        trk_exp_snap = exp_now;
        rcv_int      = trk_rcv - trk_rcv_snap;
        trk_rcv_snap = trk_rcv;
        lost         = exp_int - rcv_int;
        if (exp_int != 32'd0 && lost != 32'd0 && !lost[31]) begin
          quot = {lost, 8'h00} / {8'h00, exp_int};
          res.fraction_lost = (quot > 40'd255) ? FRAC_SAT : quot[7:0];
        end
      end
    end
    res.extended_max_seq = ext_highest();
    res.received_count   = trk_rcv;
    res.expected_count   = expected_total();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  task automatic queue_item(input in_data_t item);
    pending_items.push_back(item);
    results_owed++;
  endtask

  task automatic queue_packet(input logic [15:0] s);
    in_data_t    item;
    logic [15:0] gap;
    logic [15:0] nxt;
    gap = s - gen_cursor;
    nxt = s + 16'd1;
    if (gap < lim_dropout) begin
      gen_cursor = s;
    end else if ({1'b0, gap} <= SEQ_SPACE - {1'b0, lim_misorder}) begin
      if ({1'b0, s} == gen_bad) begin
        gen_cursor = s;
        gen_bad    = NO_MATCH;
      end else begin
        gen_bad = {1'b0, nxt};
      end
    end
    item.kind       = KIND_PACKET;
    item.seq_number = s;
    queue_item(item);
  endtask

  // The sequence field of a report is ignored, so it carries random bits.
  task automatic queue_report();
    in_data_t item;
    item.kind       = KIND_REPORT;
    item.seq_number = 16'($urandom);
    queue_item(item);
  endtask

  task automatic wait_idle();
    wait (results_owed == 0);
  endtask

  // One register write on the configuration channel; the shadow limits change
  // at the edge where the write takes place.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DROP_LIMIT:    lim_dropout  = val;
      REG_REORDER_LIMIT: lim_misorder = val;
      REG_RUN_LENGTH:    lim_min_seq  = val[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-order traffic with losses, with boundary gaps, reordering,
  // jumps (often followed by their successor, which forces a resync), noise
  // and report requests mixed in.
  task automatic queue_random_traffic(input int n);
    int          count;
    int          r;
    int          k;
    logic [15:0] j;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        queue_packet(gen_cursor + 16'd1);
      end else if (r < 70) begin
        k = $urandom_range(2, 40);
        queue_packet(gen_cursor + k[15:0]);
      end else if (r < 75) begin
        k = lim_dropout - $urandom_range(0, 1);
        queue_packet(gen_cursor + k[15:0]);
      end else if (r < 80) begin
        if ($urandom_range(0, 1) == 0) begin
          k = $urandom_range(0, 60);
        end else begin
          k = lim_misorder + 1 - $urandom_range(0, 2);
        end
        queue_packet(gen_cursor - k[15:0]);
      end else if (r < 86) begin
        j = 16'($urandom);
        queue_packet(j);
        if ($urandom_range(0, 2) != 0) begin
          queue_packet(j + 16'd1);
          count++;
        end
      end else if (r < 88) begin
        j = 16'($urandom);
        queue_packet(j);
      end else begin
        queue_report();
      end
      count++;
    end
  endtask

  // A new phase starts once the unit is idle: all three limits are written,
  // the stimulus shaper is aligned with the tracker, and traffic is queued.
  task automatic run_phase(input logic [15:0] dropout, input logic [15:0] misorder,
                           input logic [3:0] min_seq, input bit zero_limits);
    logic [15:0] j;
    wait_idle();
    write_reg(REG_DROP_LIMIT, dropout);
    write_reg(REG_REORDER_LIMIT, misorder);
    write_reg(REG_RUN_LENGTH, {12'd0, min_seq});
    gen_cursor = trk_highest;
    gen_bad    = trk_bad;
    if (zero_limits) begin
      // With both limits zero, no gap is in order and every gap is a jump:
      // a pair resyncs, a repeated jump does not, and a zero gap is a jump.
      j = 16'($urandom);
      queue_packet(j);
      queue_packet(j + 16'd1);
      queue_packet(j + 16'd2);
      queue_packet(j + 16'd2);
      queue_packet(j + 16'd3);
      queue_packet(j + 16'd3);
      queue_report();
    end
    queue_random_traffic(PHASE_ITEMS);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. The payload and
  // valid only change after the current transaction has been taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_transaction(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks every result transaction against the oldest prediction
  // and stalls in runs of no stall, light stall and heavy stall.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    out_data_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= PRINT_LIMIT) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(out_data.accepted));
          check_field("fraction_lost", 32'(want.fraction_lost),
                      32'(out_data.fraction_lost));
          check_field("extended_max_seq", want.extended_max_seq, out_data.extended_max_seq);
          check_field("received_count", want.received_count, out_data.received_count);
          check_field("expected_count", want.expected_count, out_data.expected_count);
          if (results_owed > 0) begin
            results_owed--;
          end
        end
      end
      if (stall_run_left == 0) begin
        stall_mode     = stall_mode_t'($urandom_range(0, 2));
        stall_run_left = $urandom_range(10, 150);
      end else begin
        stall_run_left--;
      end
      case (stall_mode)
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // Hang detection: any accepted transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Probation only exists right after reset, so its cases come first. With
    // a required run length of zero a restart wraps the count to fifteen.
    write_reg(REG_RUN_LENGTH, 16'd0);
    queue_packet(16'd65535);
    wait_idle();
    // After 65535 the value 0 is not in sequence, so probation restarts; the
    // next packet then completes it and synchronizes the source.
    write_reg(REG_RUN_LENGTH, 16'd2);
    queue_packet(16'd0);
    queue_packet(16'd1);

    // Valid source with the reset limits: first report after sync, losses,
    // reordering, duplicates, jump pairs, a 64K wrap, the edge of the misorder
    // window and two unpaired jumps.
    queue_report();
    queue_packet(16'd2);
    queue_packet(16'd5);
    queue_packet(16'd4);
    queue_packet(16'd4);
    queue_report();
    queue_packet(16'd40000);
    queue_packet(16'd40001);
    queue_packet(16'd40002);
    queue_report();
    queue_packet(16'd65534);
    queue_packet(16'd65535);
    queue_packet(16'd0);
    queue_packet(16'd1);
    queue_report();
    queue_packet(16'd10);
    queue_report();
    queue_packet(16'd65446);
    queue_packet(16'd65447);
    queue_packet(16'd3009);
    queue_packet(16'd6009);
    queue_report();

    // Randomized phases over several settings, extremes included.
    run_phase(16'd3000, 16'd100, 4'd2, 1'b0);
    run_phase(16'd65535, 16'd65535, 4'd15, 1'b0);
    run_phase(16'd1, 16'd0, 4'd1, 1'b0);
    run_phase(16'd0, 16'd0, 4'd0, 1'b1);
    run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
              4'($urandom_range(2, 15)), 1'b0);
    run_phase(16'd20, 16'd10, 4'd3, 1'b0);
    run_phase(16'($urandom_range(1, 100)), 16'($urandom_range(0, 100)), 4'd2, 1'b0);
    run_phase(16'd3000, 16'd100, 4'd2, 1'b0);

    // Drain, then leave room for any stray result before judging the run.
    wait_idle();
    repeat (30) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, expected_results.size());
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/rtpst_pkg.sv
sv/rtpst_pkt_logic.sv
sv/rtp_sequence_tracker_unit.sv
tb/sv/rtp_sequence_tracker_unit_tb.sv
